// ----- rtl/core/pts_pkg.sv -----
package pts_pkg;

   // default and upper bound of the task table size
   localparam int unsigned MAX_TASK_SLOTS_DEF = 32;
   localparam int unsigned MAX_TASK_SLOTS_LIM = 256;

   // widest slot id the cell row carries (covers the upper bound)
   localparam int unsigned ID_MAX_W = $clog2(MAX_TASK_SLOTS_LIM + 1);

   localparam int unsigned PRIO_W  = 8;
   localparam int unsigned REQ_W   = 2;
   localparam int unsigned TID_W   = 6;

   localparam logic [PRIO_W-1:0] PRIO_NONE = 8'd255;

   typedef enum logic [REQ_W-1:0] {
      REQ_CREATE   = 2'd0,
      REQ_SCHEDULE = 2'd1,
      REQ_BLOCK    = 2'd2,
      REQ_UNBLOCK  = 2'd3
   } pts_req_type;

   typedef enum logic [1:0] {
      STAT_READY   = 2'd0,
      STAT_RUNNING = 2'd1,
      STAT_BLOCKED = 2'd2
   } pts_status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CREATE,
      OP_BLOCK,
      OP_UNBLOCK,
      OP_SWITCH
   } pts_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_REPORT
   } pts_state_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      pts_op_type          op;
      logic [ID_MAX_W-1:0] slot_a;   // target id
      logic [ID_MAX_W-1:0] slot_b;   // previous running id on a switch
      logic [PRIO_W-1:0]   prio;
   } pts_cmd_type;

   // best candidate handed from cell to cell
   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [ID_MAX_W-1:0] slot;
   } pts_carry_type;

endpackage

// ----- rtl/core/pts_cell.sv -----
module pts_cell #(
   parameter int unsigned CellId = 1
) (
   input  logic                               clock,
   input  pts_pkg::pts_cmd_type               cmd,
   input  logic [pts_pkg::ID_MAX_W-1:0]       total,
   input  logic [pts_pkg::ID_MAX_W-1:0]       running_slot,
   input  pts_pkg::pts_carry_type             carry_i,
   output pts_pkg::pts_carry_type             carry_o,
   output logic                               run_hit
);

   localparam logic [pts_pkg::ID_MAX_W-1:0] ID = pts_pkg::ID_MAX_W'(CellId);

   logic [pts_pkg::PRIO_W-1:0]  prio_ff, prio_in;
   pts_pkg::pts_status_type     status_ff, status_in;
   pts_pkg::pts_carry_type      carry_ff, carry_in;
   logic                        valid;
   logic                        take;

   assign valid = (ID <= total);

   // apply the broadcast command to this task entry
   always_comb begin
      prio_in   = prio_ff;
      status_in = status_ff;
      case (cmd.op)
         pts_pkg::OP_CREATE: begin
            if (cmd.slot_a == ID) begin
               prio_in   = cmd.prio;
               status_in = pts_pkg::STAT_READY;
            end
         end
         pts_pkg::OP_BLOCK: begin
            if (cmd.slot_a == ID) status_in = pts_pkg::STAT_BLOCKED;
         end
         pts_pkg::OP_UNBLOCK: begin
            if (cmd.slot_a == ID && status_ff == pts_pkg::STAT_BLOCKED)
               status_in = pts_pkg::STAT_READY;
         end
         pts_pkg::OP_SWITCH: begin
            if (cmd.slot_b == ID && status_ff == pts_pkg::STAT_RUNNING)
               status_in = pts_pkg::STAT_READY;
            if (cmd.slot_a == ID) status_in = pts_pkg::STAT_RUNNING;
         end
         default: begin
         end
      endcase
   end

   // strict compare keeps the lower slot on ties
   always_comb begin
      take = 1'b0;
      if (valid) begin
         if ((status_ff == pts_pkg::STAT_READY || status_ff == pts_pkg::STAT_RUNNING)
             && prio_ff < carry_i.prio)
            take = 1'b1;
      end
      carry_in = carry_i;
      if (take) begin
         carry_in.prio = prio_ff;
         carry_in.slot = ID;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff   <= prio_in;
      status_ff <= status_in;
      carry_ff  <= carry_in;
   end

   assign carry_o = carry_ff;
   assign run_hit = valid && (running_slot == ID) && (status_ff == pts_pkg::STAT_RUNNING);

endmodule

// ----- rtl/core/pts_row.sv -----
module pts_row #(
   parameter int unsigned MAX_TASK_SLOTS = pts_pkg::MAX_TASK_SLOTS_DEF
) (
   input  logic                           clock,
   input  pts_pkg::pts_cmd_type           cmd,
   input  logic [pts_pkg::ID_MAX_W-1:0]   total,
   input  logic [pts_pkg::ID_MAX_W-1:0]   running_slot,
   output pts_pkg::pts_carry_type         best,
   output logic                           run_hit
);

   pts_pkg::pts_carry_type carry [MAX_TASK_SLOTS+1];
   logic [MAX_TASK_SLOTS-1:0] hit;

   // head of the chain: no candidate yet
   assign carry[0].prio = pts_pkg::PRIO_NONE;
   assign carry[0].slot = '0;

   for (genvar i = 0; i < MAX_TASK_SLOTS; i++) begin : g_cell
      pts_cell #(
         .CellId (i + 1)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .total        (total),
         .running_slot (running_slot),
         .carry_i      (carry[i]),
         .carry_o      (carry[i+1]),
         .run_hit      (hit[i])
      );
   end

   assign best    = carry[MAX_TASK_SLOTS];
   assign run_hit = |hit;

endmodule

// ----- rtl/core/priority_task_scheduler_top.sv -----
// Fixed-priority preemptive task scheduler.
// Request channel (req_valid/req_ready): one word per call, carrying
// req_type (create, schedule, block running, unblock), req_priority_req
// for create and req_task_id for unblock. Result channel
// (rsp_valid/rsp_ready): exactly one word per request with the id given by
// create, the dispatch flag and the id of the task running afterwards.
// The task table lives in a row of cells, one per slot. A schedule call
// sends a best-candidate word down that row, one cell per cycle, and
// applies the switch once the sweep has passed every cell; create, block
// and unblock skip the sweep. Each request then passes the apply and
// report states before its result is registered. One request is in
// flight at a time; the next can be accepted as soon as the result is
// parked in the output register, even if the receiver has not yet taken
// it. If the receiver stalls, the finished result holds in that register
// and the result of the following request waits in the report state.
// Reset (synchronous) empties the table and clears the running task; task
// entries themselves need no clearing since only created slots are read.
module priority_task_scheduler_top #(
   parameter int unsigned MAX_TASK_SLOTS = pts_pkg::MAX_TASK_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pts_pkg::REQ_W-1:0]     req_type,
   input  logic [pts_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [pts_pkg::TID_W-1:0]     req_task_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pts_pkg::TID_W-1:0]     rsp_new_task_id,
   output logic                          rsp_dispatched,
   output logic [pts_pkg::TID_W-1:0]     rsp_running_task_id
);

   localparam int unsigned IDW  = $clog2(MAX_TASK_SLOTS + 1);
   localparam int unsigned CNTW = $clog2(MAX_TASK_SLOTS);
   localparam int unsigned CW   = (IDW > pts_pkg::TID_W) ? IDW : pts_pkg::TID_W;
   localparam logic [IDW-1:0]  SLOTS    = IDW'(MAX_TASK_SLOTS);
   localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MAX_TASK_SLOTS - 1);

   pts_pkg::pts_state_type          state_ff, state_in;
   pts_pkg::pts_req_type            type_ff, type_in;
   logic [pts_pkg::PRIO_W-1:0]      prio_ff, prio_in;
   logic [pts_pkg::TID_W-1:0]       tid_ff, tid_in;
   logic [IDW-1:0]                  total_ff, total_in;
   logic [IDW-1:0]                  running_ff, running_in;
   logic [CNTW-1:0]                 cnt_ff, cnt_in;
   logic [IDW-1:0]                  new_id_ff, new_id_in;
   logic                            disp_ff, disp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pts_pkg::TID_W-1:0]       rsp_new_id_ff, rsp_new_id_in;
   logic                            rsp_disp_ff, rsp_disp_in;
   logic [pts_pkg::TID_W-1:0]       rsp_run_ff, rsp_run_in;

   pts_pkg::pts_cmd_type            cmd;
   pts_pkg::pts_carry_type          best;
   logic [IDW-1:0]                  best_id;
   logic                            run_hit;
   logic                            out_free;
   logic                            unblock_ok;

   pts_row #(
      .MAX_TASK_SLOTS (MAX_TASK_SLOTS)
   ) u_row (
      .clock        (clock),
      .cmd          (cmd),
      .total        (pts_pkg::ID_MAX_W'(total_ff)),
      .running_slot (pts_pkg::ID_MAX_W'(running_ff)),
      .best         (best),
      .run_hit      (run_hit)
   );

   assign best_id    = IDW'(best.slot);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign unblock_ok = (tid_ff != '0) && (CW'(tid_ff) <= CW'(total_ff));

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      prio_in       = prio_ff;
      tid_in        = tid_ff;
      total_in      = total_ff;
      running_in    = running_ff;
      cnt_in        = cnt_ff;
      new_id_in     = new_id_ff;
      disp_in       = disp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_new_id_in = rsp_new_id_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_run_in    = rsp_run_ff;
      req_ready     = 1'b0;
      cmd.op        = pts_pkg::OP_NONE;
      cmd.slot_a    = '0;
      cmd.slot_b    = '0;
      cmd.prio      = prio_ff;

      case (state_ff)
         pts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in = pts_pkg::pts_req_type'(req_type);
               prio_in = req_priority_req;
               tid_in  = req_task_id;
               cnt_in  = '0;
               // only schedule needs the candidate sweep down the row
               if (pts_pkg::pts_req_type'(req_type) == pts_pkg::REQ_SCHEDULE)
                  state_in = pts_pkg::ST_SCAN;
               else
                  state_in = pts_pkg::ST_APPLY;
            end
         end
         pts_pkg::ST_SCAN: begin
            // advance until the sweep has passed every cell
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = pts_pkg::ST_APPLY;
         end
         pts_pkg::ST_APPLY: begin
            new_id_in = '0;
            disp_in   = 1'b0;
            state_in  = pts_pkg::ST_REPORT;
            case (type_ff)
               pts_pkg::REQ_CREATE: begin
                  if (total_ff < SLOTS) begin
                     cmd.op     = pts_pkg::OP_CREATE;
                     cmd.slot_a = pts_pkg::ID_MAX_W'(total_ff + 1'b1);
                     total_in   = total_ff + 1'b1;
                     new_id_in  = total_ff + 1'b1;
                  end
               end
               pts_pkg::REQ_SCHEDULE: begin
                  if (best_id != '0) begin
                     cmd.op     = pts_pkg::OP_SWITCH;
                     cmd.slot_a = pts_pkg::ID_MAX_W'(best_id);
                     // demote the previous task only on a real switch
                     if (best_id != running_ff && running_ff != '0
                         && running_ff <= total_ff)
                        cmd.slot_b = pts_pkg::ID_MAX_W'(running_ff);
                     disp_in    = (best_id != running_ff);
                     running_in = best_id;
                  end
               end
               pts_pkg::REQ_BLOCK: begin
                  if (running_ff != '0 && running_ff <= total_ff) begin
                     cmd.op     = pts_pkg::OP_BLOCK;
                     cmd.slot_a = pts_pkg::ID_MAX_W'(running_ff);
                  end
               end
               pts_pkg::REQ_UNBLOCK: begin
                  if (unblock_ok) begin
                     cmd.op     = pts_pkg::OP_UNBLOCK;
                     cmd.slot_a = pts_pkg::ID_MAX_W'(tid_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         pts_pkg::ST_REPORT: begin
            // hold here while the previous result is still waiting
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_new_id_in = pts_pkg::TID_W'(new_id_ff);
               rsp_disp_in   = disp_ff;
               rsp_run_in    = run_hit ? pts_pkg::TID_W'(running_ff) : '0;
               state_in      = pts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pts_pkg::ST_IDLE;
         total_ff     <= '0;
         running_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         running_ff   <= running_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      prio_ff       <= prio_in;
      tid_ff        <= tid_in;
      new_id_ff     <= new_id_in;
      disp_ff       <= disp_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_run_ff    <= rsp_run_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_task_id     = rsp_new_id_ff;
   assign rsp_dispatched      = rsp_disp_ff;
   assign rsp_running_task_id = rsp_run_ff;

endmodule

// ----- rtl/core/pts_checker.sv -----
module pts_checker #(
   parameter int unsigned MAX_TASK_SLOTS = pts_pkg::MAX_TASK_SLOTS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pts_pkg::TID_W-1:0]     rsp_new_task_id,
   input logic                          rsp_dispatched,
   input logic [pts_pkg::TID_W-1:0]     rsp_running_task_id
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_task_id)
         && $stable(rsp_dispatched) && $stable(rsp_running_task_id))
      else $error("result word changed while stalled");

   // one request at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a dispatch always leaves a task running
   a_disp_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dispatched |-> rsp_running_task_id != '0)
      else $error("dispatch without a running task");

   // create never reports a dispatch
   a_create_nodisp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_task_id != '0 |-> !rsp_dispatched)
      else $error("create word reports a dispatch");

endmodule

bind priority_task_scheduler_top pts_checker #(
   .MAX_TASK_SLOTS (MAX_TASK_SLOTS)
) u_pts_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_new_task_id     (rsp_new_task_id),
   .rsp_dispatched      (rsp_dispatched),
   .rsp_running_task_id (rsp_running_task_id)
);
